// File: rtl/core/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 3;
  localparam int VALUE_W  = 16;  // width of the code_value field
  localparam int LENF_W   = 5;   // width of the code_length field
  localparam int SYM_W    = 8;
  localparam int OP_W     = 2;
  localparam int WIN_W    = 3 * BYTE_W;  // pending byte plus up to two code bytes

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage

// File: rtl/core/huffman_bit_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_bit_packer_core
// Huffman encoder with a loadable code table, MSB-first byte packing.
// ----------------------------------------------------------------------------
// Items enter at up to one per cycle while the pack stage can accept. A load
// item writes the code table at the accept edge; an encode item reads it at
// the accept edge and is packed from the pack-stage register against the
// pending byte, which yields zero, one or two output bytes at once. These go
// to a two-entry output buffer that drains one byte per cycle while out_ready
// is high, so an item giving two bytes holds the input until the buffer
// drains. The code table is a single-port memory with registered read;
// per-entry valid flops make it read as zero after reset, so no clearing pass
// is needed.
module huffman_bit_packer_core
  import hbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOL_COUNT  = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    opcode,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [VALUE_W-1:0] code_value,
  input  logic [LENF_W-1:0]  code_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last_of_run
);

  localparam int CAP_BITS = (MAX_CODE_BITS < VALUE_W) ? MAX_CODE_BITS : VALUE_W;
  localparam int LEN_W    = $clog2(CAP_BITS + 1);
  localparam int IDX_W    = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W  = CAP_BITS + LEN_W;

  // ---------------- accept / table access ----------------
  logic                  in_fire;
  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic [LENF_W-1:0]     len_sat;
  logic [VALUE_W:0]      len_mask;
  logic [VALUE_W-1:0]    val_masked;

  logic [ENTRY_W-1:0]    code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tab_valid;

  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx      = symbol[IDX_W-1:0];

  always_comb begin
    len_sat    = (code_length > LENF_W'(CAP_BITS)) ? LENF_W'(CAP_BITS) : code_length;
    len_mask   = ((VALUE_W + 1)'(1) << len_sat) - (VALUE_W + 1)'(1);
    val_masked = code_value & len_mask[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_fire && op_t'(opcode) == OP_LOAD && in_range) begin
      code_mem[idx] <= {len_sat[LEN_W-1:0], val_masked[CAP_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_valid <= '0;
    end else if (in_fire && op_t'(opcode) == OP_LOAD && in_range) begin
      tab_valid[idx] <= 1'b1;
    end
  end

  // ---------------- pack stage ----------------
  logic                s1_valid;
  op_t                 s1_op;
  logic                s1_inrange;
  logic                s1_rd_valid;
  logic [ENTRY_W-1:0]  s1_rd;
  logic                s1_fire;
  logic                room;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd       <= code_mem[idx];
      s1_rd_valid <= tab_valid[idx];
      s1_op       <= op_t'(opcode);
      s1_inrange  <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  logic [BYTE_W-1:0] pend_byte, pend_byte_next;
  logic [CNT_W-1:0]  pend_count, pend_count_next;
  logic [LENF_W-1:0] s1_len;
  logic [LENF_W-1:0] total;
  logic [WIN_W-1:0]  win;
  logic [1:0]        n_res;
  res_t              r0, r1;

  always_comb begin
    s1_len = (s1_op == OP_ENCODE && s1_inrange && s1_rd_valid)
           ? LENF_W'(s1_rd[ENTRY_W-1:CAP_BITS]) : '0;
    total  = LENF_W'(pend_count) + s1_len;
    // place the code's first bit right after the pending bits
    win    = {pend_byte, {(WIN_W - BYTE_W){1'b0}}};
    if (s1_len != '0) begin
      win = win | (WIN_W'(s1_rd[CAP_BITS-1:0]) << (LENF_W'(WIN_W) - total));
    end

    n_res           = 2'd0;
    r0.data         = win[WIN_W-1 -: BYTE_W];
    r1.data         = win[WIN_W-BYTE_W-1 -: BYTE_W];
    pend_byte_next  = pend_byte;
    pend_count_next = pend_count;
    case (s1_op)
      OP_ENCODE: begin
        n_res           = total[LENF_W-1:CNT_W];
        pend_count_next = total[CNT_W-1:0];
        case (total[LENF_W-1:CNT_W])
          2'd0:    pend_byte_next = win[WIN_W-1 -: BYTE_W];
          2'd1:    pend_byte_next = win[WIN_W-BYTE_W-1 -: BYTE_W];
          default: pend_byte_next = win[BYTE_W-1:0];
        endcase
      end
      OP_FLUSH: begin
        n_res           = (pend_count != '0) ? 2'd1 : 2'd0;
        r0.data         = pend_byte;
        pend_byte_next  = '0;
        pend_count_next = '0;
      end
      default: ;
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_byte  <= '0;
      pend_count <= '0;
    end else if (s1_fire) begin
      pend_byte  <= pend_byte_next;
      pend_count <= pend_count_next;
    end
  end

  // ---------------- output buffer ----------------
  res_t       q0, q1;
  logic [1:0] q_cnt;
  logic       pop;

  assign pop      = (q_cnt != 2'd0) && out_ready;
  // take a new item only when the buffer will be empty after this edge
  assign room     = (q_cnt == 2'd0) || (q_cnt == 2'd1 && out_ready);
  assign s1_fire  = s1_valid && room;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (s1_fire && n_res != 2'd0) begin
      q0 <= r0;
      q1 <= r1;
    end else if (pop) begin
      q0 <= q1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else if (s1_fire && n_res != 2'd0) begin
      q_cnt <= n_res;
    end else if (pop) begin
      q_cnt <= q_cnt - 2'd1;
    end
  end

  assign out_valid   = (q_cnt != 2'd0);
  assign out_byte    = q0.data;
  assign last_of_run = q0.last;

endmodule

// File: rtl/core/hbp_checker.sv
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks for the Huffman bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hbp_checker
  import hbp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output item changed");

  // a byte that is not the last of its item is always followed by another
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("item run ended without last_of_run");

  // with the output buffer empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output buffer");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind huffman_bit_packer_core hbp_checker u_hbp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
